// ===== rtl/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, types and tables for the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

   // default configuration of the pipeline
   localparam int ANGLE_FRAC_BITS_DEF = 23;
   localparam int CORDIC_STAGES_DEF   = 24;

   // bits of a square root of a Q60 value no larger than one
   localparam int ROOT_BITS = 31;

   // register reset and output limit
   localparam logic [23:0] RADIUS_RESET = 24'd6371000;
   localparam logic [25:0] DIST_MAX     = 26'h3FFFFFF;

   // CORDIC gain preset (Q30) and pi in Q29
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [30:0]        PI_Q29   = 31'd1686629713;

   // reciprocals of 45 for the degree conversion
   localparam logic [31:0] RECIP45       = 32'd3054198966;
   localparam int          RECIP45_SHIFT = 37;
   localparam logic [19:0] RECIP45_SMALL = 20'd745654;
   localparam int          RECIP45_SMALL_SHIFT = 25;

   // CORDIC datapath word
   typedef logic signed [33:0] cordic_type;

   // arctangent of 2^-i as a binary angle, 2^32 per turn
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   function automatic cordic_type atan_step(input int idx);
      atan_step = $signed({2'b00, ATAN_TURNS[idx]});
   endfunction

endpackage

// ===== rtl/hvd_deg2turn.sv =====
// ----------------------------------------------------------------------------
// hvd_deg2turn
// Four-stage conversion of a fixed-point degree magnitude to a binary angle,
// dividing by 360 (or 720 for half angles) through reciprocals of 45.
// ----------------------------------------------------------------------------
module hvd_deg2turn #(
   parameter int ANGLE_FRAC_BITS = 23,
   parameter bit HALF            = 1'b0
) (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] mag,
   input  logic        neg,
   output logic [31:0] ang_ff
);
   import hvd_pkg::*;

   localparam int SHIFT = 29 - ANGLE_FRAC_BITS - int'(HALF);
   localparam int TW    = 7 + SHIFT;

   logic [26:0]    q0_ff;
   logic [31:0]    mag_a_ff;
   logic           neg_a_ff;
   logic [63:0]    prod_a;
   logic [32:0]    rem_b;
   logic [6:0]     rem7_b;
   logic [26:0]    qm_in;
   logic [26:0]    qm_b_ff;
   logic [26:0]    qm_c_ff;
   logic [TW-1:0]  t_in;
   logic [TW-1:0]  t_b_ff;
   logic [TW-1:0]  t_c_ff;
   logic           neg_b_ff;
   logic           neg_c_ff;
   logic [TW+19:0] prod_c;
   logic [TW-1:0]  qr0_ff;
   logic [TW-1:0]  rr_d;
   logic [31:0]    q_d;
   logic [31:0]    ang_in;

   // stage A: estimate m/45
   assign prod_a = 64'(mag) * 64'(RECIP45);

   // stage B: correct quotient, scale remainder
   always_comb begin
      rem_b  = {1'b0, mag_a_ff} - 33'(33'(q0_ff) * 33'd45);
      rem7_b = rem_b[6:0];
      qm_in  = q0_ff;
      if (rem7_b >= 7'd45) begin
         rem7_b = rem7_b - 7'd45;
         qm_in  = q0_ff + 27'd1;
      end
      t_in = TW'((TW'(rem7_b) << SHIFT) + TW'(22));
   end

   // stage C: estimate remainder term / 45
   assign prod_c = (TW+20)'(t_b_ff) * (TW+20)'(RECIP45_SMALL);

   // stage D: correct, combine and apply sign
   always_comb begin
      rr_d = t_c_ff - TW'(qr0_ff * TW'(45));
      q_d  = (32'(qm_c_ff) << SHIFT) + 32'(qr0_ff);
      if (rr_d >= TW'(45)) begin
         q_d = q_d + 32'd1;
      end
      ang_in = neg_c_ff ? (32'd0 - q_d) : q_d;
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff    <= prod_a[RECIP45_SHIFT +: 27];
         mag_a_ff <= mag;
         neg_a_ff <= neg;
         qm_b_ff  <= qm_in;
         t_b_ff   <= t_in;
         neg_b_ff <= neg_a_ff;
         qr0_ff   <= TW'(prod_c >> RECIP45_SMALL_SHIFT);
         t_c_ff   <= t_b_ff;
         qm_c_ff  <= qm_b_ff;
         neg_c_ff <= neg_b_ff;
         ang_ff   <= ang_in;
      end
   end

endmodule

// ===== rtl/hvd_sincos.sv =====
// ----------------------------------------------------------------------------
// hvd_sincos
// Rotation-mode CORDIC lane: quadrant reduction, one micro-rotation per
// stage, then quadrant mapping and clamping of the cosine or sine.
// ----------------------------------------------------------------------------
module hvd_sincos #(
   parameter int CORDIC_STAGES = 24,
   parameter bit USE_SINE      = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        ang,
   output logic signed [31:0] val_ff
);
   import hvd_pkg::*;

   localparam int N = CORDIC_STAGES;

   cordic_type  x_ff [0:N];
   cordic_type  y_ff [0:N];
   cordic_type  z_ff [0:N];
   logic [1:0]  q_ff [0:N];
   cordic_type  x_in [1:N];
   cordic_type  y_in [1:N];
   cordic_type  z_in [1:N];
   logic [1:0]  quad;
   logic [31:0] red;
   cordic_type  c_m;
   cordic_type  s_m;
   cordic_type  pick;
   logic signed [31:0] val_in;

   // reduce to [-1/8, 1/8] turn
   always_comb begin
      quad = 2'(({2'b00, ang} + 34'h020000000) >> 30);
      red  = ang - {quad, 30'd0};
   end

   // micro-rotations
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (!z_ff[i][33]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_step(i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_step(i);
         end
      end
   end

   // map back to the quadrant and clamp to [-1, 1]
   always_comb begin
      unique case (q_ff[N])
         2'd1: begin
            c_m = -y_ff[N];
            s_m = x_ff[N];
         end
         2'd2: begin
            c_m = -x_ff[N];
            s_m = -y_ff[N];
         end
         2'd3: begin
            c_m = y_ff[N];
            s_m = -x_ff[N];
         end
         default: begin
            c_m = x_ff[N];
            s_m = y_ff[N];
         end
      endcase
      pick = USE_SINE ? s_m : c_m;
      if (pick > 34'sd1073741824) begin
         val_in = 32'sd1073741824;
      end else if (pick < -34'sd1073741824) begin
         val_in = -32'sd1073741824;
      end else begin
         val_in = 32'(pick);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= cordic_type'($signed(red));
         q_ff[0] <= quad;
         for (int i = 1; i <= N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            q_ff[i] <= q_ff[i-1];
         end
         val_ff <= val_in;
      end
   end

endmodule

// ===== rtl/hvd_isqrt.sv =====
// ----------------------------------------------------------------------------
// hvd_isqrt
// Pipelined digit-by-digit floor square root of a 61-bit value, one result
// bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
   input  logic                              clock,
   input  logic                              en,
   input  logic [60:0]                       num,
   output logic [hvd_pkg::ROOT_BITS-1:0]     root
);
   import hvd_pkg::*;

   logic [61:0] n_ff [0:ROOT_BITS-1];
   logic [61:0] r_ff [0:ROOT_BITS-1];
   logic [61:0] n_in [0:ROOT_BITS-1];
   logic [61:0] r_in [0:ROOT_BITS-1];
   logic [61:0] n_prev;
   logic [61:0] r_prev;
   logic [61:0] trial;
   logic [61:0] bit_k;

   // one root bit per stage, trial bit 2^(60-2k)
   always_comb begin
      for (int k = 0; k < ROOT_BITS; k++) begin
         n_prev = (k == 0) ? {1'b0, num} : n_ff[(k == 0) ? 0 : k-1];
         r_prev = (k == 0) ? '0 : r_ff[(k == 0) ? 0 : k-1];
         bit_k  = 62'd1 << (60 - 2*k);
         trial  = r_prev + bit_k;
         if (n_prev >= trial) begin
            n_in[k] = n_prev - trial;
            r_in[k] = (r_prev >> 1) + bit_k;
         end else begin
            n_in[k] = n_prev;
            r_in[k] = r_prev >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROOT_BITS; k++) begin
            n_ff[k] <= n_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[ROOT_BITS-1][ROOT_BITS-1:0];

endmodule

// ===== rtl/hvd_atan.sv =====
// ----------------------------------------------------------------------------
// hvd_atan
// Vectoring-mode CORDIC for atan2(y, x) with x, y >= 0, one micro-rotation
// per stage, result clamped to a quarter turn.
// ----------------------------------------------------------------------------
module hvd_atan #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] y,
   input  logic [30:0] x,
   output logic [30:0] z_ff
);
   import hvd_pkg::*;

   localparam int N = CORDIC_STAGES;

   cordic_type  x_ff [1:N];
   cordic_type  y_ff [1:N];
   cordic_type  zz_ff [1:N];
   cordic_type  x_in [1:N];
   cordic_type  y_in [1:N];
   cordic_type  z_in [1:N];
   cordic_type  xp;
   cordic_type  yp;
   cordic_type  zp;
   logic [30:0] z_in_out;

   // micro-rotations toward the x axis
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            xp = cordic_type'(x);
            yp = cordic_type'(y);
            zp = '0;
         end else begin
            xp = x_ff[(i == 0) ? 1 : i];
            yp = y_ff[(i == 0) ? 1 : i];
            zp = zz_ff[(i == 0) ? 1 : i];
         end
         if (!yp[33] && (yp != '0)) begin
            x_in[i+1] = xp + (yp >>> i);
            y_in[i+1] = yp - (xp >>> i);
            z_in[i+1] = zp + atan_step(i);
         end else begin
            x_in[i+1] = xp - (yp >>> i);
            y_in[i+1] = yp + (xp >>> i);
            z_in[i+1] = zp - atan_step(i);
         end
      end
   end

   // clamp to [0, quarter turn]
   always_comb begin
      if (zz_ff[N][33]) begin
         z_in_out = '0;
      end else if (zz_ff[N] > 34'sd1073741824) begin
         z_in_out = 31'd1073741824;
      end else begin
         z_in_out = 31'(zz_ff[N]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 1; i <= N; i++) begin
            x_ff[i]  <= x_in[i];
            y_ff[i]  <= y_in[i];
            zz_ff[i] <= z_in[i];
         end
         z_ff <= z_in_out;
      end
   end

endmodule

// ===== rtl/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two positions given in fixed-point degrees.
//
// Usage: present a request (two latitude/longitude pairs) with req_valid;
// it is taken when req_ready is high. One distance in whole meters comes
// back per request on rsp_valid/rsp_ready, in request order, rounded and
// saturated. csr_wr_en writes the sphere radius in meters; write it only
// while no request is in flight.
// The longest parts of the pipeline are the two CORDIC pipelines and
// the 31-stage square root. Throughput: one request per cycle unless
// stalled; the whole pipeline advances as one.
// Stall: while rsp_valid is high and rsp_ready low, every stage holds and
// req_ready is low; nothing is dropped or repeated.
// Reset: clears all valid bits and loads the radius with 6371000 meters.
// ----------------------------------------------------------------------------
module haversine_distance #(
   parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = hvd_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_distance_m,
   input  logic               csr_wr_en,
   input  logic [23:0]        csr_wr_data
);
   import hvd_pkg::*;

   localparam int LATENCY = 2*CORDIC_STAGES + 13 + ROOT_BITS + 2;

   logic               adv;
   logic               vld_ff [0:LATENCY-1];
   logic [23:0]        radius_ff;

   logic signed [31:0] dlat;
   logic signed [32:0] dlon;
   logic [31:0]        mag_ff [0:3];
   logic               neg_ff [0:3];
   logic [31:0]        mag_in [0:3];
   logic               neg_in [0:3];
   logic [31:0]        ang [0:3];

   logic signed [31:0] c1;
   logic signed [31:0] c2;
   logic signed [31:0] sl;
   logic signed [31:0] sn;

   logic signed [63:0] prod_cc;
   logic signed [63:0] prod_ss;
   logic signed [31:0] p_ff;
   logic [60:0]        slsq_ff;
   logic signed [31:0] sn1_ff;
   logic signed [63:0] prod_ps;
   logic signed [31:0] ps_ff;
   logic [60:0]        slsq2_ff;
   logic signed [31:0] sn2_ff;
   logic signed [63:0] a_raw;
   logic [60:0]        a_in;
   logic [60:0]        a_ff;
   logic [60:0]        a2_ff;
   logic [60:0]        b_ff;

   logic [30:0]        root_a;
   logic [30:0]        root_b;
   logic [30:0]        z;
   logic [61:0]        prod_u;
   logic [34:0]        v_ff;
   logic [58:0]        prod_d;
   logic [26:0]        d_ff;
   logic [25:0]        dist_ff;

   // whole pipeline moves unless a finished result is held
   assign adv       = rsp_ready | ~rsp_valid;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_distance_m = dist_ff;

   // carry valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   // input stage: differences and sign/magnitude split
   always_comb begin
      dlat = 32'(req_second_latitude) - 32'(req_first_latitude);
      dlon = 33'(req_second_longitude) - 33'(req_first_longitude);
      neg_in[0] = req_first_latitude[30];
      neg_in[1] = req_second_latitude[30];
      neg_in[2] = dlat[31];
      neg_in[3] = dlon[32];
      mag_in[0] = neg_in[0] ? 32'(-33'(req_first_latitude))  : 32'(req_first_latitude);
      mag_in[1] = neg_in[1] ? 32'(-33'(req_second_latitude)) : 32'(req_second_latitude);
      mag_in[2] = neg_in[2] ? 32'(-33'(dlat)) : 32'(dlat);
      mag_in[3] = neg_in[3] ? 32'(-dlon) : 32'(dlon);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            mag_ff[i] <= mag_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
   end

   // degree to binary angle, full angles for latitudes, half for differences
   hvd_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .HALF(1'b0)) u_turn_lat1 (
      .clock(clock), .en(adv), .mag(mag_ff[0]), .neg(neg_ff[0]), .ang_ff(ang[0]));
   hvd_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .HALF(1'b0)) u_turn_lat2 (
      .clock(clock), .en(adv), .mag(mag_ff[1]), .neg(neg_ff[1]), .ang_ff(ang[1]));
   hvd_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .HALF(1'b1)) u_turn_dlat (
      .clock(clock), .en(adv), .mag(mag_ff[2]), .neg(neg_ff[2]), .ang_ff(ang[2]));
   hvd_deg2turn #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .HALF(1'b1)) u_turn_dlon (
      .clock(clock), .en(adv), .mag(mag_ff[3]), .neg(neg_ff[3]), .ang_ff(ang[3]));

   // sines and cosines
   hvd_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .USE_SINE(1'b0)) u_cos_lat1 (
      .clock(clock), .en(adv), .ang(ang[0]), .val_ff(c1));
   hvd_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .USE_SINE(1'b0)) u_cos_lat2 (
      .clock(clock), .en(adv), .ang(ang[1]), .val_ff(c2));
   hvd_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .USE_SINE(1'b1)) u_sin_dlat (
      .clock(clock), .en(adv), .ang(ang[2]), .val_ff(sl));
   hvd_sincos #(.CORDIC_STAGES(CORDIC_STAGES), .USE_SINE(1'b1)) u_sin_dlon (
      .clock(clock), .en(adv), .ang(ang[3]), .val_ff(sn));

   // haversine term over three multiply stages, then clamp and complement
   always_comb begin
      prod_cc = 64'(c1) * 64'(c2);
      prod_ss = 64'(sl) * 64'(sl);
      prod_ps = 64'(p_ff) * 64'(sn1_ff);
      a_raw   = $signed({3'b000, slsq2_ff}) + 64'(ps_ff) * 64'(sn2_ff);
      if (a_raw < 64'sd0) begin
         a_in = '0;
      end else if (a_raw > 64'sh1000000000000000) begin
         a_in = 61'h1000000000000000;
      end else begin
         a_in = 61'(a_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff     <= 32'((prod_cc + 64'sd536870912) >>> 30);
         slsq_ff  <= 61'(prod_ss);
         sn1_ff   <= sn;
         ps_ff    <= 32'((prod_ps + 64'sd536870912) >>> 30);
         slsq2_ff <= slsq_ff;
         sn2_ff   <= sn1_ff;
         a_ff     <= a_in;
         a2_ff    <= a_ff;
         b_ff     <= 61'h1000000000000000 - a_ff;
      end
   end

   // square roots of a and 1 - a
   hvd_isqrt u_sqrt_a (.clock(clock), .en(adv), .num(a2_ff), .root(root_a));
   hvd_isqrt u_sqrt_b (.clock(clock), .en(adv), .num(b_ff),  .root(root_b));

   // central half-angle
   hvd_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan (
      .clock(clock), .en(adv), .y(root_a), .x(root_b), .z_ff(z));

   // angle to radians, times radius, round and saturate
   always_comb begin
      prod_u = 62'(z) * 62'(PI_Q29);
      prod_d = 59'(v_ff) * 59'(radius_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff    <= 35'((prod_u + 62'd67108864) >> 27);
         d_ff    <= 27'((prod_d + 59'd2147483648) >> 32);
         dist_ff <= d_ff[26] ? DIST_MAX : d_ff[25:0];
      end
   end

endmodule

// ===== rtl/hvd_checker.sv =====
// ----------------------------------------------------------------------------
// hvd_checker
// Port-level checks of the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module hvd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [25:0] rsp_distance_m
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_m))
      else $error("held response changed");

   // an empty output never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with no pending response");

   // a stalled output stalls the input
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   // a waiting request stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before acceptance");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_distance_m(rsp_distance_m)
);
